// ----- hdl/byte_ring_buffer_top_defines.svh -----
// Assertion macros used by the byte ring buffer top level.
`ifndef BYTE_RING_BUFFER_TOP_DEFINES_SVH
`define BYTE_RING_BUFFER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that post holds in the same cycle as pre.
`define BRB_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("byte ring buffer: same-cycle check failed");

// Check that post holds in the cycle after pre.
`define BRB_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("byte ring buffer: next-cycle check failed");

`else

`define BRB_ASSERT_SAME(label, pre, post)
`define BRB_ASSERT_NEXT(label, pre, post)

`endif

`endif

// ----- hdl/brb_pkg.sv -----
// Package with types, constants and codes of the byte ring buffer.
`timescale 1ns / 1ps
package brb_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int MAX_BURST_DEF = 8;

  localparam int REQ_W      = 3;
  localparam int COUNT_W    = 4;
  localparam int DATA_W     = 64;
  localparam int AMOUNT_W   = 10;
  localparam int LEVEL_W    = 10;
  localparam int LANE_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int S_TDATA_W  = 80;
  localparam int M_TDATA_W  = 96;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE      = 3'd0,
    REQ_READ       = 3'd1,
    REQ_PEEK       = 3'd2,
    REQ_WRITE_ADV  = 3'd3,
    REQ_READ_ADV   = 3'd4,
    REQ_RESET      = 3'd5,
    REQ_STATUS     = 3'd6
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WRITE,
    ST_READ,
    ST_RDLAST,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               load;
    logic               wr_en;
    logic               rd_en;
    logic               capture;
    logic               commit;
    logic               emit;
    logic [COUNT_W-1:0] idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t               req;
    logic [COUNT_W-1:0] done;
  } stat_t;

endpackage

// ----- hdl/byte_ring_buffer_top.sv -----
// Top level of the byte ring buffer: stream ports, controller and datapath.
`timescale 1ns / 1ps
`include "byte_ring_buffer_top_defines.svh"
//
// Byte FIFO over a DEPTH-entry byte store; it holds at most DEPTH-1 bytes.
// Requests enter on the s_ channel: s_tuser carries the request type (write,
// read, peek, write advance, read advance, reset, status), s_tdata the byte
// count, up to eight write bytes and the advance distance.
// Each request gives exactly one result on the m_ channel: bytes accepted,
// read data, fill level, free space and the empty flag after the request.
// Requests are handled one at a time through the controller states: dispatch,
// one write state per byte for a write, one read state per byte and a
// last-capture state for a read or peek of n > 0 bytes (n after clipping, at
// most MAX_BURST), then commit and emit; the next request is taken back in
// idle. The byte-wide store port is walked one byte per cycle.
// s_tready is high only while no request is in progress.
// A finished result sits in the output register; the next request is taken
// while it waits, and that request stalls before its own result until the
// receiver takes the pending one with m_tready.
// Reset (rst, synchronous) clears both pointers and drops any pending result.
// Store contents are not cleared; a read request never returns unwritten bytes
// unless an advance request moves a pointer over them.
module byte_ring_buffer_top #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEF,
  parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [3:0] byte_count, [67:4] write_data, [77:68] advance_amount, [79:78] zero
  input  logic [brb_pkg::S_TDATA_W-1:0] s_tdata,
  // [2:0] req_type
  input  logic [brb_pkg::REQ_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [3:0] accepted_count, [67:4] read_data, [77:68] fill_level,
  // [87:78] free_space, [88] empty_flag, [95:89] zero
  output logic [brb_pkg::M_TDATA_W-1:0] m_tdata
);

  brb_pkg::cmd_t  cmd;
  brb_pkg::stat_t stat;

  logic [brb_pkg::COUNT_W-1:0] accepted_count;
  logic [brb_pkg::DATA_W-1:0]  read_data;
  logic [brb_pkg::LEVEL_W-1:0] fill_level;
  logic [brb_pkg::LEVEL_W-1:0] free_space;
  logic                        empty_flag;

  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  brb_datapath #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .req_type       (s_tuser),
    .byte_count     (s_tdata[3:0]),
    .write_data     (s_tdata[67:4]),
    .advance_amount (s_tdata[77:68]),
    .cmd            (cmd),
    .stat           (stat),
    .accepted_count (accepted_count),
    .read_data      (read_data),
    .fill_level     (fill_level),
    .free_space     (free_space),
    .empty_flag     (empty_flag)
  );

  assign m_tdata = {7'b0, empty_flag, free_space, fill_level, read_data, accepted_count};

  `BRB_ASSERT_SAME(a_count_in_burst, m_tvalid, accepted_count <= brb_pkg::COUNT_W'(MAX_BURST))
  `BRB_ASSERT_SAME(a_empty_no_fill, m_tvalid && empty_flag, fill_level == '0)
  `BRB_ASSERT_SAME(a_no_bytes_no_data, m_tvalid && accepted_count == '0, read_data == '0)
  `BRB_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready)

endmodule

// ----- hdl/brb_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/brb_ctrl.sv -----
// Controller state machine: sequences one request through the byte store.
`timescale 1ns / 1ps
module brb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  brb_pkg::stat_t stat,
  output brb_pkg::cmd_t  cmd
);

  brb_pkg::state_t state, state_next;
  logic [brb_pkg::COUNT_W-1:0] idx, idx_next;
  logic out_valid, out_valid_next;
  logic [brb_pkg::COUNT_W-1:0] last_idx;

  assign last_idx = stat.done - brb_pkg::COUNT_W'(1);
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brb_pkg::ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    s_tready   = 1'b0;
    cmd        = '0;
    cmd.idx    = idx;
    case (state)
      brb_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = brb_pkg::ST_DISPATCH;
        end
      end
      brb_pkg::ST_DISPATCH: begin
        idx_next = '0;
        case (stat.req)
          brb_pkg::REQ_WRITE: begin
            state_next = (stat.done != '0) ? brb_pkg::ST_WRITE : brb_pkg::ST_COMMIT;
          end
          brb_pkg::REQ_READ, brb_pkg::REQ_PEEK: begin
            state_next = (stat.done != '0) ? brb_pkg::ST_READ : brb_pkg::ST_COMMIT;
          end
          default: begin
            state_next = brb_pkg::ST_COMMIT;
          end
        endcase
      end
      brb_pkg::ST_WRITE: begin
        cmd.wr_en = 1'b1;
        idx_next  = idx + brb_pkg::COUNT_W'(1);
        if (idx == last_idx) begin
          state_next = brb_pkg::ST_COMMIT;
        end
      end
      brb_pkg::ST_READ: begin
        // Issue byte idx, capture the byte issued in the previous cycle.
        cmd.rd_en   = 1'b1;
        cmd.capture = (idx != '0);
        idx_next    = idx + brb_pkg::COUNT_W'(1);
        if (idx == last_idx) begin
          state_next = brb_pkg::ST_RDLAST;
        end
      end
      brb_pkg::ST_RDLAST: begin
        cmd.capture = 1'b1;
        state_next  = brb_pkg::ST_COMMIT;
      end
      brb_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = brb_pkg::ST_EMIT;
      end
      brb_pkg::ST_EMIT: begin
        // Hold until the output register is free.
        if (!out_valid || m_tready) begin
          cmd.emit   = 1'b1;
          state_next = brb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = brb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ----- hdl/brb_datapath.sv -----
// Datapath: pointers, clipping, byte store access and the result register.
`timescale 1ns / 1ps
module brb_datapath #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEF,
  parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [brb_pkg::REQ_W-1:0]     req_type,
  input  logic [brb_pkg::COUNT_W-1:0]   byte_count,
  input  logic [brb_pkg::DATA_W-1:0]    write_data,
  input  logic [brb_pkg::AMOUNT_W-1:0]  advance_amount,
  input  brb_pkg::cmd_t                 cmd,
  output brb_pkg::stat_t                stat,
  output logic [brb_pkg::COUNT_W-1:0]   accepted_count,
  output logic [brb_pkg::DATA_W-1:0]    read_data,
  output logic [brb_pkg::LEVEL_W-1:0]   fill_level,
  output logic [brb_pkg::LEVEL_W-1:0]   free_space,
  output logic                          empty_flag
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CMP_W = (PTR_W > brb_pkg::COUNT_W) ? PTR_W : brb_pkg::COUNT_W;

  logic [PTR_W-1:0]              rp, wp;
  brb_pkg::req_t                 req;
  logic [brb_pkg::DATA_W-1:0]    wdata;
  logic [brb_pkg::AMOUNT_W-1:0]  amount;
  logic [brb_pkg::COUNT_W-1:0]   done;
  logic [brb_pkg::DATA_W-1:0]    rdata;

  logic [PTR_W-1:0]              fill_now, free_now, limit;
  logic [brb_pkg::COUNT_W-1:0]   want, clip;
  logic [brb_pkg::LANE_W-1:0]    wr_lane, cap_lane;
  logic [PTR_W-1:0]              wr_addr, rd_addr;
  logic [brb_pkg::BYTE_W-1:0]    ram_q;

  assign fill_now = wp - rp;
  assign free_now = rp - wp - PTR_W'(1);

  // Clip the burst to MAX_BURST, then to the free space or the fill level.
  always_comb begin
    if (byte_count > brb_pkg::COUNT_W'(MAX_BURST)) begin
      want = brb_pkg::COUNT_W'(MAX_BURST);
    end else begin
      want = byte_count;
    end
    if (brb_pkg::req_t'(req_type) == brb_pkg::REQ_WRITE) begin
      limit = free_now;
    end else begin
      limit = fill_now;
    end
    if (CMP_W'(limit) < CMP_W'(want)) begin
      clip = brb_pkg::COUNT_W'(limit);
    end else begin
      clip = want;
    end
  end

  assign stat.req  = req;
  assign stat.done = done;

  assign wr_lane  = brb_pkg::LANE_W'(cmd.idx);
  assign cap_lane = brb_pkg::LANE_W'(cmd.idx - brb_pkg::COUNT_W'(1));
  assign wr_addr  = wp + PTR_W'(cmd.idx);
  assign rd_addr  = rp + PTR_W'(cmd.idx);

  brb_ram #(
    .WIDTH (brb_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wdata[wr_lane*brb_pkg::BYTE_W +: brb_pkg::BYTE_W]),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0;
      wp <= '0;
    end else if (cmd.commit) begin
      case (req)
        brb_pkg::REQ_WRITE: begin
          wp <= wp + PTR_W'(done);
        end
        brb_pkg::REQ_READ: begin
          rp <= rp + PTR_W'(done);
        end
        brb_pkg::REQ_WRITE_ADV: begin
          wp <= wp + PTR_W'(amount);
        end
        brb_pkg::REQ_READ_ADV: begin
          rp <= rp + PTR_W'(amount);
        end
        brb_pkg::REQ_RESET: begin
          rp <= '0;
          wp <= '0;
        end
        default: begin
          rp <= rp;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req    <= brb_pkg::req_t'(req_type);
      wdata  <= write_data;
      amount <= advance_amount;
      done   <= clip;
    end
    if (cmd.load) begin
      rdata <= '0;
    end else if (cmd.capture) begin
      rdata[cap_lane*brb_pkg::BYTE_W +: brb_pkg::BYTE_W] <= ram_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (req)
        brb_pkg::REQ_WRITE, brb_pkg::REQ_READ, brb_pkg::REQ_PEEK: begin
          accepted_count <= done;
        end
        default: begin
          accepted_count <= '0;
        end
      endcase
      read_data  <= rdata;
      fill_level <= brb_pkg::LEVEL_W'(fill_now);
      free_space <= brb_pkg::LEVEL_W'(free_now);
      empty_flag <= (rp == wp);
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the byte ring buffer: directed and random requests.
`timescale 1ns / 1ps
module testbench;

  localparam int          DEPTH       = brb_pkg::DEPTH_DEF;
  localparam int          MAX_BURST   = brb_pkg::MAX_BURST_DEF;
  localparam int          REQ_W       = brb_pkg::REQ_W;
  localparam int          COUNT_W     = brb_pkg::COUNT_W;
  localparam int          DATA_W      = brb_pkg::DATA_W;
  localparam int          AMOUNT_W    = brb_pkg::AMOUNT_W;
  localparam int          LEVEL_W     = brb_pkg::LEVEL_W;
  localparam int          S_TDATA_W   = brb_pkg::S_TDATA_W;
  localparam int          M_TDATA_W   = brb_pkg::M_TDATA_W;
  localparam int          PTR_W       = $clog2(DEPTH);
  localparam logic [2:0]  REQ_UNKNOWN = 3'd7;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          LONG_HOLD   = 400;
  localparam int          RANDOM_REQS = 1450;
  localparam int          CHUNK_REQS  = 50;

  typedef struct packed {
    logic [COUNT_W-1:0] accepted;
    logic [DATA_W-1:0]  data;
    logic [LEVEL_W-1:0] fill;
    logic [LEVEL_W-1:0] space;
    logic               empty;
  } brb_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [REQ_W-1:0]     s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  // Shadow copy of the FIFO.
  logic [7:0]       store_img [0:DEPTH-1];
  logic [PTR_W-1:0] rd_ptr = '0;
  logic [PTR_W-1:0] wr_ptr = '0;

  brb_result_t expected_results [$];

  bit src_pacing    = 1'b0;
  bit sink_pacing   = 1'b0;
  bit long_hold_req = 1'b0;
  int sink_hold     = 0;
  int cycle_count   = 0;
  int fail_count    = 0;
  int results_seen  = 0;
  int full_hits     = 0;
  int empty_hits    = 0;
  int input_stalls  = 0;
  int req_seen [8];

  byte_ring_buffer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    else if (roll < 90) return $urandom_range(1, 14);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [COUNT_W-1:0] random_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    else if (roll < 15) return COUNT_W'($urandom_range(MAX_BURST + 1, 15));
    else return COUNT_W'($urandom_range(1, MAX_BURST));
  endfunction

  // Apply one request to the shadow FIFO and return the result it should produce.
  function automatic brb_result_t apply_request(input logic [REQ_W-1:0] code,
                                                input logic [COUNT_W-1:0] count,
                                                input logic [DATA_W-1:0] wdata,
                                                input logic [AMOUNT_W-1:0] amount);
    brb_result_t      r;
    logic [COUNT_W-1:0] want;
    logic [PTR_W-1:0] level;
    logic [PTR_W-1:0] addr;
    r = '0;
    want = (count > MAX_BURST) ? COUNT_W'(MAX_BURST) : count;
    case (code)
      brb_pkg::REQ_WRITE: begin
        level = rd_ptr - wr_ptr - 1'b1;
        r.accepted = (level < want) ? COUNT_W'(level) : want;
        for (int k = 0; k < r.accepted; k++) begin
          addr = wr_ptr + PTR_W'(k);
          store_img[addr] = wdata[8*k +: 8];
        end
        wr_ptr = wr_ptr + PTR_W'(r.accepted);
      end
      brb_pkg::REQ_READ, brb_pkg::REQ_PEEK: begin
        level = wr_ptr - rd_ptr;
        r.accepted = (level < want) ? COUNT_W'(level) : want;
        for (int k = 0; k < r.accepted; k++) begin
          addr = rd_ptr + PTR_W'(k);
          r.data[8*k +: 8] = store_img[addr];
        end
        if (code == brb_pkg::REQ_READ) rd_ptr = rd_ptr + PTR_W'(r.accepted);
      end
      brb_pkg::REQ_WRITE_ADV: wr_ptr = wr_ptr + PTR_W'(amount);
      brb_pkg::REQ_READ_ADV:  rd_ptr = rd_ptr + PTR_W'(amount);
      brb_pkg::REQ_RESET: begin
        rd_ptr = '0;
        wr_ptr = '0;
      end
      default: ;
    endcase
    level = wr_ptr - rd_ptr;
    r.fill = LEVEL_W'(level);
    level = rd_ptr - wr_ptr - 1'b1;
    r.space = LEVEL_W'(level);
    r.empty = (rd_ptr == wr_ptr);
    return r;
  endfunction

  // Offer one request, wait for the handshake, then record its expected result.
  task automatic send_request(input logic [REQ_W-1:0] code, input logic [COUNT_W-1:0] count,
                              input logic [DATA_W-1:0] wdata,
                              input logic [AMOUNT_W-1:0] amount);
    int          gap;
    brb_result_t res;
    gap = src_pacing ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= code;
    s_tdata  <= {2'b00, amount, wdata, count};
    do @(posedge clk); while (!s_tready);
    res = apply_request(code, count, wdata, amount);
    expected_results.push_back(res);
    req_seen[code]++;
    if (res.space == 0) full_hits++;
    if (res.empty) empty_hits++;
  endtask

  task automatic send_simple(input logic [REQ_W-1:0] code, input logic [COUNT_W-1:0] count);
    send_request(code, count, {$urandom, $urandom}, AMOUNT_W'($urandom_range(0, 1023)));
  endtask

  task automatic wait_for_results();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Status, read and peek on an empty FIFO touch no store entry.
  task automatic test_reset_state();
    src_pacing  = 1'b0;
    sink_pacing = 1'b0;
    send_simple(brb_pkg::REQ_STATUS, 4'd0);
    send_simple(brb_pkg::REQ_READ, 4'd8);
    send_simple(brb_pkg::REQ_PEEK, 4'd8);
  endtask

  // Fill to full, drain to empty, then wrap so that every store entry holds data.
  task automatic test_fill_and_drain();
    src_pacing  = 1'b1;
    sink_pacing = 1'b1;
    for (int i = 0; i < (DEPTH - 1) / MAX_BURST; i++) send_simple(brb_pkg::REQ_WRITE, 4'd8);
    send_simple(brb_pkg::REQ_WRITE, 4'd15);
    send_simple(brb_pkg::REQ_WRITE, 4'd8);
    send_simple(brb_pkg::REQ_STATUS, 4'd0);
    for (int i = 0; i < (DEPTH - 1) / MAX_BURST; i++) send_simple(brb_pkg::REQ_READ, 4'd8);
    send_simple(brb_pkg::REQ_READ, 4'd15);
    send_simple(brb_pkg::REQ_READ, 4'd3);
    send_simple(brb_pkg::REQ_PEEK, 4'd8);
    send_simple(brb_pkg::REQ_WRITE, 4'd8);
  endtask

  task automatic test_request_codes();
    src_pacing  = 1'b0;
    sink_pacing = 1'b0;
    send_request(brb_pkg::REQ_WRITE, 4'd0, {64{1'b1}}, 10'd0);
    send_request(brb_pkg::REQ_WRITE, 4'd8, {64{1'b1}}, {AMOUNT_W{1'b1}});
    send_request(brb_pkg::REQ_WRITE, 4'd15, 64'h0, 10'd0);
    send_simple(brb_pkg::REQ_PEEK, 4'd15);
    send_simple(brb_pkg::REQ_PEEK, 4'd0);
    send_simple(brb_pkg::REQ_READ, 4'd3);
    send_simple(brb_pkg::REQ_READ, 4'd15);
    send_request(brb_pkg::REQ_STATUS, 4'd15, 64'h0, {AMOUNT_W{1'b1}});
    send_simple(REQ_UNKNOWN, 4'd8);
    // Push the write pointer past the read pointer, then look at the odd levels.
    send_request(brb_pkg::REQ_WRITE_ADV, 4'd0, 64'h0, {AMOUNT_W{1'b1}});
    send_simple(brb_pkg::REQ_PEEK, 4'd8);
    send_request(brb_pkg::REQ_READ_ADV, 4'd0, 64'h0, {AMOUNT_W{1'b1}});
    send_simple(brb_pkg::REQ_READ, 4'd8);
    send_request(brb_pkg::REQ_WRITE_ADV, 4'd0, 64'h0, 10'd0);
    send_request(brb_pkg::REQ_READ_ADV, 4'd0, 64'h0, 10'd0);
    send_request(brb_pkg::REQ_READ_ADV, 4'd0, 64'h0, 10'd600);
    send_simple(brb_pkg::REQ_WRITE, 4'd5);
    send_simple(brb_pkg::REQ_RESET, 4'd8);
    send_simple(brb_pkg::REQ_STATUS, 4'd0);
    send_simple(brb_pkg::REQ_WRITE, 4'd8);
    send_simple(brb_pkg::REQ_READ, 4'd8);
  endtask

  // Hold the result side off for a long stretch while requests keep coming.
  task automatic test_input_backpressure();
    src_pacing    = 1'b0;
    sink_pacing   = 1'b0;
    long_hold_req = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_simple(brb_pkg::REQ_WRITE, 4'd8);
      send_simple(brb_pkg::REQ_PEEK, random_count());
    end
  endtask

  task automatic test_random_traffic();
    int               w_pct;
    int               r_pct;
    int               roll;
    logic [REQ_W-1:0] code;
    logic [AMOUNT_W-1:0] amount;
    for (int c = 0; c < RANDOM_REQS / CHUNK_REQS; c++) begin
      src_pacing  = ($urandom_range(0, 3) != 0);
      sink_pacing = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0: begin w_pct = 35; r_pct = 30; end
        1: begin w_pct = 60; r_pct = 15; end
        default: begin w_pct = 15; r_pct = 50; end
      endcase
      for (int i = 0; i < CHUNK_REQS; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < w_pct) code = brb_pkg::REQ_WRITE;
        else if (roll < w_pct + r_pct) code = brb_pkg::REQ_READ;
        else begin
          roll = $urandom_range(0, 99);
          if (roll < 35) code = brb_pkg::REQ_PEEK;
          else if (roll < 50) code = brb_pkg::REQ_WRITE_ADV;
          else if (roll < 65) code = brb_pkg::REQ_READ_ADV;
          else if (roll < 72) code = brb_pkg::REQ_RESET;
          else if (roll < 88) code = brb_pkg::REQ_STATUS;
          else code = REQ_UNKNOWN;
        end
        amount = $urandom_range(0, 1) ? AMOUNT_W'($urandom_range(0, 16))
                                      : AMOUNT_W'($urandom_range(0, 1023));
        send_request(code, random_count(), {$urandom, $urandom}, amount);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_hold <= 0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      m_tready  <= 1'b0;
      sink_hold <= LONG_HOLD;
    end else if (sink_hold != 0) begin
      m_tready  <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (sink_pacing && $urandom_range(0, 99) < 25) begin
      m_tready  <= 1'b0;
      sink_hold <= idle_len();
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    brb_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: m_tdata %h", m_tdata);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[3:0] !== want.accepted) begin
          $error("accepted_count: expected %0d, got %0d", want.accepted, m_tdata[3:0]);
          fail_count++;
        end
        if (m_tdata[67:4] !== want.data) begin
          $error("read_data: expected %h, got %h", want.data, m_tdata[67:4]);
          fail_count++;
        end
        if (m_tdata[77:68] !== want.fill) begin
          $error("fill_level: expected %0d, got %0d", want.fill, m_tdata[77:68]);
          fail_count++;
        end
        if (m_tdata[87:78] !== want.space) begin
          $error("free_space: expected %0d, got %0d", want.space, m_tdata[87:78]);
          fail_count++;
        end
        if (m_tdata[88] !== want.empty) begin
          $error("empty_flag: expected %0d, got %0d", want.empty, m_tdata[88]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (s_tvalid && !s_tready) input_stalls++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL byte_ring_buffer_top");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_fill_and_drain();
    test_request_codes();
    test_input_backpressure();
    test_random_traffic();
    s_tvalid <= 1'b0;
    wait_for_results();
    $display("Checked %0d results (%0d wr, %0d rd, %0d peek, %0d adv, %0d rst, %0d stat)",
             results_seen, req_seen[brb_pkg::REQ_WRITE], req_seen[brb_pkg::REQ_READ],
             req_seen[brb_pkg::REQ_PEEK],
             req_seen[brb_pkg::REQ_WRITE_ADV] + req_seen[brb_pkg::REQ_READ_ADV],
             req_seen[brb_pkg::REQ_RESET],
             req_seen[brb_pkg::REQ_STATUS] + req_seen[REQ_UNKNOWN]);
    $display("FIFO full after %0d requests, empty after %0d; input stalled for %0d cycles",
             full_hits, empty_hits, input_stalls);
    if (fail_count == 0) begin
      $display("PASS byte_ring_buffer_top");
    end else begin
      $display("FAIL byte_ring_buffer_top");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/brb_pkg.sv
hdl/brb_ram.sv
hdl/brb_ctrl.sv
hdl/brb_datapath.sv
hdl/byte_ring_buffer_top.sv
sim/testbench.sv
